/* rtl/lph_pkg.sv */
package lph_pkg;

    localparam int KEY_BITS    = 32;
    localparam int IN_VAL_BITS = 16;
    localparam int STATUS_BITS = 3;

    localparam logic [KEY_BITS-1:0] HASH_MULT = 32'h9E37_79B1;

    localparam logic [STATUS_BITS-1:0] STATUS_FOUND = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISS  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NEW   = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_OVER  = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 3'd4;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO  = 3'd5;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

endpackage

/* rtl/lph_hash.sv */
module lph_hash
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_done,
    output logic [AW-1:0]       o_bucket
);

    if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_pow2
        logic [KEY_BITS-1:0] r_prod;
        logic                r_busy;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
            end else begin
                r_busy <= i_start;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_prod <= KEY_BITS'(i_key * HASH_MULT);
            end
        end

        assign o_done   = r_busy;
        assign o_bucket = r_prod[AW-1:0];
    end else begin : g_div
        localparam logic [AW:0] DEPTH_W = (AW+1)'(TABLE_DEPTH);
        localparam logic [KEY_BITS-1:0] RECIP =
            KEY_BITS'((64'd1 << KEY_BITS) / 64'(TABLE_DEPTH));

        logic [KEY_BITS-1:0]   r_prod;
        logic [KEY_BITS-1:0]   r_quot;
        logic [AW-1:0]         r_rem;
        logic                  r_prod_vld;
        logic                  r_quot_vld;
        logic                  r_done;
        logic [2*KEY_BITS-1:0] quot_full;
        logic [AW:0]           rem_est;
        logic [AW:0]           rem_fix;

        // quotient estimate by reciprocal, at most one short, then one subtract
        assign quot_full = (2*KEY_BITS)'(r_prod) * (2*KEY_BITS)'(RECIP);
        assign rem_est   = r_prod[AW:0] - (AW+1)'(r_quot[AW:0] * DEPTH_W);
        assign rem_fix   = (rem_est >= DEPTH_W) ? rem_est - DEPTH_W : rem_est;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_prod_vld <= 1'b0;
                r_quot_vld <= 1'b0;
                r_done     <= 1'b0;
            end else begin
                r_prod_vld <= i_start;
                r_quot_vld <= r_prod_vld;
                r_done     <= r_quot_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_prod <= KEY_BITS'(i_key * HASH_MULT);
            end
            if (r_prod_vld) begin
                r_quot <= quot_full[2*KEY_BITS-1:KEY_BITS];
            end
            if (r_quot_vld) begin
                r_rem <= rem_fix[AW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end

endmodule

/* rtl/lph_mem.sv */
module lph_mem
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192,
    parameter int VALUE_BITS  = 16,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [KEY_BITS-1:0]   o_rd_key,
    output logic [VALUE_BITS-1:0] o_rd_val,
    input  logic                  i_key_we,
    input  logic                  i_val_we,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [VALUE_BITS-1:0] i_wr_val
);

    logic [KEY_BITS-1:0]   r_key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        if (i_rd_en) begin
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

/* rtl/linear_probe_hash_map_top.sv */
// Open-addressing hash map from 32-bit keys to stored values, linear probing.
// Request channel (s_axis): tdata = lookup_key, entry_value; tuser = op
// (find or insert/overwrite). Result channel (m_axis): tdata = found_value;
// tuser = hit, status. Exactly one result per request, in request order.
// Flow: a nonzero key is hashed to its home bucket and buckets are probed
// from there until a result; one key-memory read per bucket, streamed one
// per cycle from a read-ahead pointer. With a TABLE_DEPTH that is not a
// power of two, the hash adds a remainder unit. A zero key is not hashed;
// its result is formed in the cycle it is accepted. One request is in
// flight at a time; the next is accepted the cycle after the result has
// been loaded into the output register.
// Reset: a clearing pass writes an empty key into every bucket, one per
// cycle, with s_axis tready low; stored values are not cleared. Stall: a
// waiting result holds the output register; a request can still be accepted,
// and its result waits in the block until the output frees.
module linear_probe_hash_map_top
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192,
    parameter int VALUE_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // lookup_key[31:0], entry_value[47:32]
    input  logic        i_s_axis_tuser,   // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // found_value[15:0]
    output logic [3:0]  o_m_axis_tuser    // hit[0], status[3:1]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_op;
    logic [KEY_BITS-1:0]    r_key;
    logic [IN_VAL_BITS-1:0] r_val;
    logic [AW-1:0]          r_rd_addr;
    logic [AW-1:0]          r_cmp_addr;
    logic [AW-1:0]          r_cnt;
    logic                   r_data_vld;

    logic                   r_res_hit;
    logic [IN_VAL_BITS-1:0] r_res_val;
    logic [STATUS_BITS-1:0] r_res_status;
    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [IN_VAL_BITS-1:0] r_out_val;
    logic [STATUS_BITS-1:0] r_out_status;

    logic                   in_acc;
    logic                   in_op;
    logic [KEY_BITS-1:0]    in_key;
    logic [IN_VAL_BITS-1:0] in_val;
    logic                   out_free;

    logic                   hash_start;
    logic                   hash_done;
    logic [AW-1:0]          hash_bucket;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic                   key_we;
    logic                   val_we;
    logic [AW-1:0]          wr_addr;
    logic [KEY_BITS-1:0]    wr_key;
    logic [VALUE_BITS-1:0]  wr_val;

    logic [VALUE_BITS+IN_VAL_BITS-1:0] rd_val_ext;
    logic [VALUE_BITS+IN_VAL_BITS-1:0] wr_val_ext;
    logic [AW-1:0]          next_addr;
    logic                   key_empty;
    logic                   key_match;
    logic                   last_probe;
    logic                   fin;
    logic                   fin_hit;
    logic [IN_VAL_BITS-1:0] fin_val;
    logic [STATUS_BITS-1:0] fin_status;
    logic                   ins_write;

    assign in_op   = i_s_axis_tuser;
    assign in_key  = i_s_axis_tdata[KEY_BITS-1:0];
    assign in_val  = i_s_axis_tdata[KEY_BITS+IN_VAL_BITS-1:KEY_BITS];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign hash_start = in_acc && (in_key != '0);

    lph_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (in_key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    lph_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_val  (rd_val),
        .i_key_we  (key_we),
        .i_val_we  (val_we),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_val  (wr_val)
    );

    assign rd_val_ext = {{IN_VAL_BITS{1'b0}}, rd_val};
    assign wr_val_ext = {{VALUE_BITS{1'b0}}, r_val};
    assign next_addr  = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;

    assign key_empty  = (rd_key == '0);
    assign key_match  = (rd_key == r_key);
    assign last_probe = (r_cnt == LAST_ADDR);
    assign ins_write  = (r_state == S_PROBE) && r_data_vld && (r_op == OP_INSERT)
                        && (key_empty || key_match);

    // result of this cycle, from a zero key or from the bucket compare
    always_comb begin
        fin        = 1'b0;
        fin_hit    = 1'b0;
        fin_val    = '0;
        fin_status = STATUS_MISS;
        if (in_acc && (in_key == '0)) begin
            fin        = 1'b1;
            fin_status = STATUS_ZERO;
        end else if ((r_state == S_PROBE) && r_data_vld) begin
            if (r_op == OP_FIND) begin
                if (key_empty) begin
                    fin        = 1'b1;
                    fin_status = STATUS_MISS;
                end else if (key_match) begin
                    fin        = 1'b1;
                    fin_hit    = 1'b1;
                    fin_val    = rd_val_ext[IN_VAL_BITS-1:0];
                    fin_status = STATUS_FOUND;
                end else if (last_probe) begin
                    fin        = 1'b1;
                    fin_status = STATUS_MISS;
                end
            end else begin
                if (key_empty) begin
                    fin        = 1'b1;
                    fin_status = STATUS_NEW;
                end else if (key_match) begin
                    fin        = 1'b1;
                    fin_status = STATUS_OVER;
                end else if (last_probe) begin
                    fin        = 1'b1;
                    fin_status = STATUS_FULL;
                end
            end
        end
    end

    always_comb begin
        rd_en   = (r_state == S_PROBE);
        rd_addr = r_rd_addr;
        key_we  = 1'b0;
        val_we  = 1'b0;
        wr_addr = r_cmp_addr;
        wr_key  = r_key;
        wr_val  = wr_val_ext[VALUE_BITS-1:0];
        if (r_state == S_CLEAR) begin
            key_we  = 1'b1;
            wr_addr = r_clr_addr;
            wr_key  = '0;
        end else if (ins_write) begin
            key_we = 1'b1;
            val_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (fin) begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end else if (in_acc) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (fin) begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_data_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_HASH) begin
                r_data_vld <= 1'b0;
            end else if (r_state == S_PROBE) begin
                r_data_vld <= 1'b1;
            end
            if ((r_state == S_DONE) || fin) begin
                if (out_free) begin
                    r_out_vld <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= in_op;
            r_key <= in_key;
            r_val <= in_val;
        end
        if ((r_state == S_HASH) && hash_done) begin
            r_rd_addr <= hash_bucket;
            r_cnt     <= '0;
        end else if (r_state == S_PROBE) begin
            r_rd_addr  <= next_addr;
            r_cmp_addr <= r_rd_addr;
            if (r_data_vld) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (fin) begin
            r_res_hit    <= fin_hit;
            r_res_val    <= fin_val;
            r_res_status <= fin_status;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_hit    <= r_res_hit;
            r_out_val    <= r_res_val;
            r_out_status <= r_res_status;
        end else if (fin && out_free) begin
            r_out_hit    <= fin_hit;
            r_out_val    <= fin_val;
            r_out_status <= fin_status;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = {r_out_status, r_out_hit};

endmodule

/* bench/tb_linear_probe_hash_map_top.sv */
`timescale 1ns / 1ps

module tb_linear_probe_hash_map_top;
    import lph_pkg::*;

    localparam int MAP_DEPTH = 8192;
    localparam int BUCKET_BITS = $clog2(MAP_DEPTH);
    localparam logic [31:0] HASH_FACTOR = 32'h9E37_79B1;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [15:0] value;
    } map_req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] found;
        logic [2:0]  status;
    } map_rsp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;     // lookup_key[31:0], entry_value[47:32]
    logic        i_s_axis_tuser = 1'b0;   // op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;          // found_value[15:0]
    logic [3:0]  o_m_axis_tuser;          // hit[0], status[3:1]

    map_req_t    map_requests[$];
    map_rsp_t    lookup_results[$];
    logic [31:0] stored_keys[$];
    bit [31:0]   key_tab [MAP_DEPTH];
    bit [15:0]   val_tab [MAP_DEPTH];
    bit [31:0]   hash_inv;
    map_req_t    cur_req = '0;
    bit          req_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          bad_results = 0;

    linear_probe_hash_map_top #(
        .TABLE_DEPTH(MAP_DEPTH),
        .VALUE_BITS (16)
    ) dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // key whose home bucket is the given one, upper bits free
    function automatic logic [31:0] key_homed_at(int bucket, logic [31:0] upper);
        logic [31:0] low;
        logic [31:0] k;
        low = bucket * hash_inv;
        k = {upper[31:BUCKET_BITS], low[BUCKET_BITS-1:0]};
        if (k == 0) begin
            k[31] = 1'b1;
        end
        return k;
    endfunction

    function automatic map_rsp_t probe_table(map_req_t rq);
        map_rsp_t    rs;
        logic [31:0] prod;
        int          b;
        rs = '0;
        if (rq.key == 0) begin
            rs.status = STATUS_ZERO;
            return rs;
        end
        prod = rq.key * HASH_FACTOR;
        b = prod[BUCKET_BITS-1:0];
        rs.status = (rq.op == OP_FIND) ? STATUS_MISS : STATUS_FULL;
        for (int n = 0; n < MAP_DEPTH; n++) begin
            if (rq.op == OP_FIND) begin
                if (key_tab[b] == 0) begin
                    return rs;
                end
                if (key_tab[b] == rq.key) begin
                    rs.hit = 1'b1;
                    rs.found = val_tab[b];
                    rs.status = STATUS_FOUND;
                    return rs;
                end
            end else if (key_tab[b] == 0 || key_tab[b] == rq.key) begin
                rs.status = (key_tab[b] == 0) ? STATUS_NEW : STATUS_OVER;
                key_tab[b] = rq.key;
                val_tab[b] = rq.value;
                return rs;
            end
            b = (b + 1) % MAP_DEPTH;
        end
        return rs;
    endfunction

    task automatic queue_request(logic kind, logic [31:0] key_in, logic [15:0] value_in);
        map_req_t rq;
        rq.op = kind;
        rq.key = key_in;
        rq.value = value_in;
        map_requests.push_back(rq);
        if (kind == OP_INSERT && key_in != 0) begin
            stored_keys.push_back(key_in);
        end
    endtask

    // keys mostly reused or packed around a few hot buckets to build long probe chains
    task automatic queue_random_mix(int count);
        int          centers[4];
        int          r;
        logic [31:0] key;
        logic [15:0] value;
        logic        kind;
        centers[0] = 0;
        centers[1] = MAP_DEPTH - 8;
        centers[2] = $urandom_range(MAP_DEPTH - 1);
        centers[3] = $urandom_range(MAP_DEPTH - 1);
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 5) begin
                key = '0;
            end else if (r < 40 && stored_keys.size() > 0) begin
                key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            end else if (r < 80) begin
                key = key_homed_at((centers[$urandom_range(3)] + $urandom_range(31)) % MAP_DEPTH,
                                   $urandom);
            end else begin
                key = $urandom;
            end
            r = $urandom_range(9);
            value = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            kind = $urandom_range(1) ? OP_INSERT : OP_FIND;
            queue_request(kind, key, value);
        end
    endtask

    task automatic wait_drained();
        while (map_requests.size() != 0 || i_s_axis_tvalid || lookup_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin : drive
        logic offer;
        offer = i_s_axis_tvalid && !req_taken;
        req_taken = 1'b0;
        if (!offer && i_rst_n && map_requests.size() != 0
            && $urandom_range(99) >= send_idle_pct) begin
            cur_req = map_requests.pop_front();
            offer = 1'b1;
        end
        i_s_axis_tvalid <= offer;
        i_s_axis_tdata <= {cur_req.value, cur_req.key};
        i_s_axis_tuser <= cur_req.op;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check
        map_rsp_t got;
        map_rsp_t want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            lookup_results.push_back(probe_table(cur_req));
            req_taken = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.hit = o_m_axis_tuser[0];
            got.status = o_m_axis_tuser[3:1];
            got.found = o_m_axis_tdata;
            if (lookup_results.size() == 0) begin
                if (bad_results < 10) begin
                    $display("unexpected result: hit %0b value %h status %0d",
                             got.hit, got.found, got.status);
                end
                bad_results++;
            end else begin
                want = lookup_results.pop_front();
                if (got.hit !== want.hit || got.found !== want.found
                    || got.status !== want.status) begin
                    if (bad_results < 10) begin
                        $display("result mismatch: expected hit %0b value %h status %0d, %s",
                                 want.hit, want.found, want.status, "got");
                        $display("    got hit %0b value %h status %0d",
                                 got.hit, got.found, got.status);
                    end
                    bad_results++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        hash_inv = HASH_FACTOR;
        repeat (4) begin
            hash_inv = hash_inv * (32'd2 - HASH_FACTOR * hash_inv);
        end
        send_idle_pct = 24;
        recv_idle_pct = 81;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero key, extremes, overwrite
        queue_request(OP_FIND, 32'h0, 16'h0);
        queue_request(OP_INSERT, 32'h0, 16'hFFFF);
        queue_request(OP_FIND, 32'hFFFF_FFFF, 16'h0);
        queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        queue_request(OP_FIND, 32'hFFFF_FFFF, 16'h1234);
        queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
        queue_request(OP_FIND, 32'hFFFF_FFFF, 16'h0);
        queue_request(OP_INSERT, 32'h0000_0001, 16'h8001);
        queue_request(OP_INSERT, 32'h8000_0000, 16'h7FFE);
        queue_request(OP_FIND, 32'h0000_0001, 16'h0);
        queue_request(OP_FIND, 32'h8000_0000, 16'h0);

        // collision chain at the last bucket, wrapping to the start
        k0 = key_homed_at(MAP_DEPTH - 1, 32'hAAAA_0000);
        k1 = key_homed_at(MAP_DEPTH - 1, 32'h5555_0000);
        k2 = key_homed_at(MAP_DEPTH - 1, 32'hFFFF_0000);
        queue_request(OP_INSERT, k0, 16'h0101);
        queue_request(OP_INSERT, k1, 16'h0202);
        queue_request(OP_INSERT, k2, 16'h0303);
        queue_request(OP_FIND, k2, 16'h0);
        queue_request(OP_FIND, k1, 16'h0);
        queue_request(OP_FIND, key_homed_at(MAP_DEPTH - 1, 32'h1234_0000), 16'h0);
        queue_request(OP_FIND, key_homed_at(0, 32'h0F0F_0000), 16'h0);
        queue_request(OP_INSERT, k0, 16'hC3C3);
        queue_request(OP_FIND, k0, 16'h0);

        queue_random_mix(700);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 24;
        queue_random_mix(700);
        wait_drained();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_mix(60);
        queue_request(OP_INSERT, key_homed_at(MAP_DEPTH - 1, $urandom), 16'hFFFF);
        queue_request(OP_INSERT, key_homed_at($urandom_range(MAP_DEPTH - 1), $urandom),
                      16'($urandom));
        queue_request(OP_FIND, key_homed_at(0, $urandom), 16'h0);
        queue_request(OP_FIND, key_homed_at($urandom_range(MAP_DEPTH - 1), $urandom), 16'h0);
        queue_request(OP_INSERT, 32'h0, 16'h5A5A);
        queue_request(OP_FIND, 32'h0, 16'h0);
        repeat (30) begin
            queue_request($urandom_range(1) ? OP_INSERT : OP_FIND,
                          stored_keys[$urandom_range(stored_keys.size() - 1)], 16'($urandom));
        end
        wait_drained();

        repeat (64) @(posedge i_clk);
        if (bad_results == 0 && lookup_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/lph_pkg.sv
rtl/lph_hash.sv
rtl/lph_mem.sv
rtl/linear_probe_hash_map_top.sv
bench/tb_linear_probe_hash_map_top.sv
